/* hdl/udtt_pkg.sv */
// Shared types, codes and constants for the up/down tenths timer.
package udtt_pkg;

  localparam int TENTHS_W  = 14;
  localparam int SECONDS_W = 18;

  localparam logic [TENTHS_W-1:0]  TENTHS_TOP  = 14'd9999;
  localparam logic [SECONDS_W-1:0] SECONDS_TOP = 18'd219660;

  localparam logic [7:0] SEG_BLANK = 8'hFF;
  localparam logic [7:0] DP_MASK   = 8'h7F;

  // Item kinds
  localparam logic [1:0] MODE_COUNT   = 2'd0;
  localparam logic [1:0] MODE_SCAN    = 2'd1;
  localparam logic [1:0] MODE_COMMAND = 2'd2;

  // Commands
  localparam logic [2:0] CMD_UP    = 3'd0;
  localparam logic [2:0] CMD_STOP  = 3'd1;
  localparam logic [2:0] CMD_DOWN  = 3'd2;
  localparam logic [2:0] CMD_RESET = 3'd3;
  localparam logic [2:0] CMD_LOAD  = 3'd4;

  // Configuration register indexes
  localparam logic REG_DISPLAY_ENABLED = 1'b0;
  localparam logic REG_SHOW_TIMER      = 1'b1;

  // Step codes, two's complement
  localparam logic [1:0] STEP_STOP = 2'b00;
  localparam logic [1:0] STEP_UP   = 2'b01;
  localparam logic [1:0] STEP_DOWN = 2'b11;

  // Four BCD digits: [3] thousands down to [0] units.
  typedef logic [3:0][3:0] bcd_t;

  // Decoded item kind, passed from the input stage to the state units.
  typedef struct packed {
    logic count_tick;
    logic scan_tick;
    logic command;
  } event_t;

  function automatic bcd_t bcd_step(input bcd_t d, input logic down);
    bcd_t r;
    logic carry;
    r = d;
    carry = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if (carry) begin
        if (!down) begin
          if (d[i] == 4'd9) begin
            r[i] = 4'd0;
          end else begin
            r[i] = d[i] + 4'd1;
            carry = 1'b0;
          end
        end else begin
          if (d[i] == 4'd0) begin
            r[i] = 4'd9;
          end else begin
            r[i] = d[i] - 4'd1;
            carry = 1'b0;
          end
        end
      end
    end
    return r;
  endfunction

  function automatic logic [7:0] seg_font(input logic [3:0] d);
    logic [7:0] s;
    unique case (d)
      4'd0:    s = 8'hC0;
      4'd1:    s = 8'hF9;
      4'd2:    s = 8'hA4;
      4'd3:    s = 8'hB0;
      4'd4:    s = 8'h99;
      4'd5:    s = 8'h92;
      4'd6:    s = 8'h82;
      4'd7:    s = 8'hF8;
      4'd8:    s = 8'h80;
      4'd9:    s = 8'h90;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] enable_pattern(input logic [1:0] pos);
    logic [3:0] e;
    unique case (pos)
      2'd0:    e = 4'h7;
      2'd1:    e = 4'hB;
      2'd2:    e = 4'hD;
      default: e = 4'hE;
    endcase
    return e;
  endfunction

endpackage

/* hdl/udtt_count.sv */
// Tenths, seconds and direction state with its per-item update.
module udtt_count #(
  parameter int TICKS_PER_SECOND = 10
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  udtt_pkg::event_t                 ev,
  input  logic [2:0]                       command,
  input  logic [udtt_pkg::SECONDS_W-1:0]   seconds_value,
  output logic [udtt_pkg::TENTHS_W-1:0]    tenths,
  output logic [udtt_pkg::SECONDS_W-1:0]   seconds,
  output logic [1:0]                       step,
  output udtt_pkg::bcd_t                   bcd
);

  localparam int SUB_W = (TICKS_PER_SECOND > 2) ? $clog2(TICKS_PER_SECOND) : 1;
  localparam logic [SUB_W-1:0] SUB_LAST = SUB_W'(TICKS_PER_SECOND - 1);

  logic [udtt_pkg::TENTHS_W-1:0]  tenths_next;
  logic [udtt_pkg::SECONDS_W-1:0] seconds_next;
  logic [1:0]                     step_next;
  udtt_pkg::bcd_t                 bcd_next;
  logic [SUB_W-1:0]               subtick, subtick_next;

  always_comb begin
    tenths_next  = tenths;
    seconds_next = seconds;
    step_next    = step;
    bcd_next     = bcd;
    subtick_next = subtick;
    if (ev.count_tick) begin
      if (step == udtt_pkg::STEP_UP) begin
        tenths_next = (tenths == udtt_pkg::TENTHS_TOP) ? '0 : tenths + 1'b1;
        bcd_next    = udtt_pkg::bcd_step(bcd, 1'b0);
      end else if (step == udtt_pkg::STEP_DOWN) begin
        tenths_next = (tenths == '0) ? udtt_pkg::TENTHS_TOP : tenths - 1'b1;
        bcd_next    = udtt_pkg::bcd_step(bcd, 1'b1);
      end
      // The seconds count moves on the first tick of each second.
      if (subtick == '0) begin
        if (step == udtt_pkg::STEP_UP) begin
          if (seconds < udtt_pkg::SECONDS_TOP) seconds_next = seconds + 1'b1;
        end else if (step == udtt_pkg::STEP_DOWN) begin
          if (seconds == '0) step_next = udtt_pkg::STEP_STOP;
          else seconds_next = seconds - 1'b1;
        end
      end
      subtick_next = (subtick == SUB_LAST) ? '0 : subtick + 1'b1;
    end else if (ev.command) begin
      unique case (command)
        udtt_pkg::CMD_UP:   step_next = udtt_pkg::STEP_UP;
        udtt_pkg::CMD_STOP: step_next = udtt_pkg::STEP_STOP;
        udtt_pkg::CMD_DOWN: step_next = udtt_pkg::STEP_DOWN;
        udtt_pkg::CMD_RESET: begin
          step_next   = udtt_pkg::STEP_STOP;
          tenths_next = '0;
          bcd_next    = '0;
        end
        udtt_pkg::CMD_LOAD: begin
          seconds_next = (seconds_value > udtt_pkg::SECONDS_TOP) ?
                         udtt_pkg::SECONDS_TOP : seconds_value;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tenths  <= '0;
      seconds <= '0;
      step    <= udtt_pkg::STEP_STOP;
      bcd     <= '0;
      subtick <= '0;
    end else if (en) begin
      tenths  <= tenths_next;
      seconds <= seconds_next;
      step    <= step_next;
      bcd     <= bcd_next;
      subtick <= subtick_next;
    end
  end

endmodule

/* hdl/udtt_scan.sv */
// Digit scan: scan position and the segment and digit latches.
module udtt_scan (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           scan_tick,
  input  logic           display_enabled,
  input  logic           show_timer,
  input  udtt_pkg::bcd_t bcd,
  output logic [7:0]     segment_latch,
  output logic [3:0]     digit_latch
);

  logic [1:0] pos, pos_next;
  logic [7:0] segment_latch_next;
  logic [3:0] digit_latch_next;
  logic [7:0] font;

  // Position 0 shows thousands, so the digit index is the inverted position.
  assign font = udtt_pkg::seg_font(bcd[~pos]);

  always_comb begin
    pos_next           = pos;
    segment_latch_next = segment_latch;
    digit_latch_next   = digit_latch;
    if (scan_tick) begin
      if (!display_enabled) begin
        segment_latch_next = udtt_pkg::SEG_BLANK;
      end else begin
        if (show_timer) begin
          segment_latch_next = (pos == 2'd2) ? (font & udtt_pkg::DP_MASK) : font;
          digit_latch_next   = udtt_pkg::enable_pattern(pos);
        end else begin
          segment_latch_next = udtt_pkg::SEG_BLANK;
        end
        pos_next = pos + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos           <= '0;
      segment_latch <= udtt_pkg::SEG_BLANK;
      digit_latch   <= '0;
    end else if (en) begin
      pos           <= pos_next;
      segment_latch <= segment_latch_next;
      digit_latch   <= digit_latch_next;
    end
  end

endmodule

/* hdl/updown_tenths_timer_7seg_scan.sv */
// Top level of the up/down tenths timer with four-digit seven-segment scan.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one item: a count tick, a scan
//   tick or a command (up, stop, down, reset, load seconds). Every item gives
//   exactly one result on the output channel (out_valid/out_ready): the
//   segment and digit latches, the tenths and seconds counts and the step.
//   The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) sets
//   display_enabled (index 0) and show_timer (index 1); it is always ready and
//   should be written only while no item is in flight.
// Pipeline:
//   An accepted item is held in the input register, then updates the state,
//   which is the result register. One item is taken per cycle while the
//   output is not stalled, set by the single state update.
// Reset (rst, synchronous): counts and step clear, the segment latch goes to
//   all off, both configuration bits clear and both stages empty.
// Stalls: while out_ready is low the result holds; one more item can wait in
//   the input register, after which in_ready drops.
module updown_tenths_timer_7seg_scan #(
  parameter int TICKS_PER_SECOND = 10
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     mode,
  input  logic [2:0]                     command,
  input  logic [udtt_pkg::SECONDS_W-1:0] seconds_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     segments,
  output logic [3:0]                     digit_enables,
  output logic [udtt_pkg::TENTHS_W-1:0]  tenths_count,
  output logic [udtt_pkg::SECONDS_W-1:0] seconds_count,
  output logic signed [1:0]              direction,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_index,
  input  logic                           cfg_data
);

  logic                           s1_valid;
  logic [1:0]                     s1_mode;
  logic [2:0]                     s1_command;
  logic [udtt_pkg::SECONDS_W-1:0] s1_seconds_value;
  logic                           out_free;
  logic                           advance;
  logic                           display_enabled;
  logic                           show_timer;
  logic [1:0]                     step;
  udtt_pkg::event_t               ev;
  udtt_pkg::bcd_t                 bcd;

  assign out_free  = !out_valid || out_ready;
  assign advance   = s1_valid && out_free;
  assign in_ready  = !s1_valid || out_free;
  assign cfg_ready = 1'b1;

  assign ev.count_tick = (s1_mode == udtt_pkg::MODE_COUNT);
  assign ev.scan_tick  = (s1_mode == udtt_pkg::MODE_SCAN);
  assign ev.command    = (s1_mode == udtt_pkg::MODE_COMMAND);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_mode          <= mode;
      s1_command       <= command;
      s1_seconds_value <= seconds_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      display_enabled <= 1'b0;
      show_timer      <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        udtt_pkg::REG_DISPLAY_ENABLED: display_enabled <= cfg_data;
        udtt_pkg::REG_SHOW_TIMER:      show_timer      <= cfg_data;
        default: ;
      endcase
    end
  end

  udtt_count #(
    .TICKS_PER_SECOND(TICKS_PER_SECOND)
  ) u_count (
    .clk          (clk),
    .rst          (rst),
    .en           (advance),
    .ev           (ev),
    .command      (s1_command),
    .seconds_value(s1_seconds_value),
    .tenths       (tenths_count),
    .seconds      (seconds_count),
    .step         (step),
    .bcd          (bcd)
  );

  udtt_scan u_scan (
    .clk            (clk),
    .rst            (rst),
    .en             (advance),
    .scan_tick      (ev.scan_tick),
    .display_enabled(display_enabled),
    .show_timer     (show_timer),
    .bcd            (bcd),
    .segment_latch  (segments),
    .digit_latch    (digit_enables)
  );

  assign direction = step;

`ifndef SYNTHESIS
  a_tenths_range : assert property (@(posedge clk) disable iff (rst)
    tenths_count <= udtt_pkg::TENTHS_TOP)
    else $error("tenths count out of range");

  a_seconds_range : assert property (@(posedge clk) disable iff (rst)
    seconds_count <= udtt_pkg::SECONDS_TOP)
    else $error("seconds count above its top");

  a_one_digit : assert property (@(posedge clk) disable iff (rst)
    digit_enables == 4'h0 || $countones(digit_enables) == 3)
    else $error("more than one digit enabled");

  a_ready_when_empty : assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty output stage");
`endif

endmodule

/* verif/tb_updown_tenths_timer_7seg_scan.sv */
// Self-checking testbench for the up/down tenths timer with seven-segment scan.
`timescale 1ns / 100ps

module tb_updown_tenths_timer_7seg_scan;
  import udtt_pkg::*;

  localparam int TICKS         = 10;
  localparam int PHASE_ITEMS   = 160;
  localparam int SETTLE_CYCLES = 4;
  localparam int QUIET_LIMIT   = 2000;

  localparam logic [1:0]           MODE_SPARE      = 2'd3;
  localparam logic [2:0]           CMD_SPARE_FIRST = 3'd5;
  localparam logic [2:0]           CMD_SPARE_LAST  = 3'd7;
  localparam logic [SECONDS_W-1:0] VALUE_ALL_ONES  = '1;

  localparam logic [7:0] DIGIT_GLYPH [10] = '{8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99,
                                              8'h92, 8'h82, 8'hF8, 8'h80, 8'h90};
  localparam logic [3:0] DIGIT_SELECT [4] = '{4'h7, 4'hB, 4'hD, 4'hE};

  // Handshake pressure and register settings of each random phase.
  localparam int IDLE_PCT  [4] = '{0, 68, 0, 16};
  localparam int STALL_PCT [4] = '{0, 0, 68, 16};
  localparam bit DISP_BY_PHASE [4] = '{1'b1, 1'b0, 1'b1, 1'b1};
  localparam bit SHOW_BY_PHASE [4] = '{1'b1, 1'b1, 1'b0, 1'b1};

  typedef struct packed {
    logic [1:0]           mode;
    logic [2:0]           cmd;
    logic [SECONDS_W-1:0] value;
  } timer_item_t;

  typedef struct packed {
    logic [7:0]           seg;
    logic [3:0]           dig;
    logic [TENTHS_W-1:0]  tenths;
    logic [SECONDS_W-1:0] secs;
    logic [1:0]           dir;
  } timer_reading_t;

  typedef struct {
    bit             is_write;
    logic           reg_index;
    logic           reg_data;
    timer_item_t    item;
    bit             typed;
    timer_reading_t want;
  } plan_row_t;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic [1:0]            mode;
  logic [2:0]            command;
  logic [SECONDS_W-1:0]  seconds_value;
  logic                  out_valid;
  logic                  out_ready;
  logic [7:0]            segments;
  logic [3:0]            digit_enables;
  logic [TENTHS_W-1:0]   tenths_count;
  logic [SECONDS_W-1:0]  seconds_count;
  logic signed [1:0]     direction;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic                  cfg_index;
  logic                  cfg_data;

  // Predicted state of the timer and its display.
  logic                 disp_on;
  logic                 show_count;
  logic [TENTHS_W-1:0]  tmr_tenths;
  logic [SECONDS_W-1:0] tmr_secs;
  logic [1:0]           tmr_step;
  int                   tmr_subtick;
  logic [1:0]           tmr_pos;
  logic [7:0]           tmr_seg;
  logic [3:0]           tmr_dig;

  timer_reading_t expected_readings[$];
  int failures         = 0;
  int readings_checked = 0;
  int items_sent       = 0;
  int quiet_cycles     = 0;
  int send_idle_pct    = 0;
  int recv_stall_pct   = 0;

  updown_tenths_timer_7seg_scan #(.TICKS_PER_SECOND(TICKS)) dut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic advance_timer(input timer_item_t it, output timer_reading_t got);
    int digit;
    case (it.mode)
      MODE_COUNT: begin
        if (tmr_step == STEP_UP) begin
          tmr_tenths = (tmr_tenths >= TENTHS_TOP) ? '0 : tmr_tenths + 1'b1;
        end else if (tmr_step == STEP_DOWN) begin
          tmr_tenths = (tmr_tenths == '0) ? TENTHS_TOP : tmr_tenths - 1'b1;
        end
        // The seconds count moves on the first tick of each second, and the
        // tenths count has already moved when a downward count hits zero.
        if (tmr_subtick == 0) begin
          if (tmr_step == STEP_UP) begin
            if (tmr_secs < SECONDS_TOP) tmr_secs = tmr_secs + 1'b1;
          end else if (tmr_step == STEP_DOWN) begin
            if (tmr_secs == '0) begin
              tmr_step = STEP_STOP;
            end else begin
              tmr_secs = tmr_secs - 1'b1;
            end
          end
        end
        tmr_subtick = (tmr_subtick + 1 >= TICKS) ? 0 : tmr_subtick + 1;
      end
      MODE_SCAN: begin
        if (!disp_on) begin
          tmr_seg = SEG_BLANK;
        end else begin
          if (show_count) begin
            case (tmr_pos)
              2'd0:    digit = (tmr_tenths / 1000) % 10;
              2'd1:    digit = (tmr_tenths / 100) % 10;
              2'd2:    digit = (tmr_tenths / 10) % 10;
              default: digit = tmr_tenths % 10;
            endcase
            tmr_seg = DIGIT_GLYPH[digit];
            if (tmr_pos == 2'd2) tmr_seg = tmr_seg & DP_MASK;
            tmr_dig = DIGIT_SELECT[tmr_pos];
          end else begin
            // Blanked: the digit latch keeps its value but the scan moves on.
            tmr_seg = SEG_BLANK;
          end
          tmr_pos = tmr_pos + 1'b1;
        end
      end
      MODE_COMMAND: begin
        case (it.cmd)
          CMD_UP:   tmr_step = STEP_UP;
          CMD_STOP: tmr_step = STEP_STOP;
          CMD_DOWN: tmr_step = STEP_DOWN;
          CMD_RESET: begin
            // The subtick phase survives a reset command.
            tmr_step   = STEP_STOP;
            tmr_tenths = '0;
          end
          CMD_LOAD: tmr_secs = (it.value > SECONDS_TOP) ? SECONDS_TOP : it.value;
          default: ;
        endcase
      end
      default: ;
    endcase
    got = {tmr_seg, tmr_dig, tmr_tenths, tmr_secs, tmr_step};
  endtask

  function automatic plan_row_t item_row(input logic [1:0] m, input logic [2:0] c,
                                         input logic [SECONDS_W-1:0] v);
    plan_row_t row;
    row.is_write  = 1'b0;
    row.reg_index = REG_DISPLAY_ENABLED;
    row.reg_data  = 1'b0;
    row.item      = '{mode: m, cmd: c, value: v};
    row.typed     = 1'b0;
    row.want      = '0;
    return row;
  endfunction

  function automatic plan_row_t checked_row(input logic [1:0] m, input logic [2:0] c,
                                            input logic [SECONDS_W-1:0] v,
                                            input logic [7:0] seg, input logic [3:0] dig,
                                            input logic [TENTHS_W-1:0] ten,
                                            input logic [SECONDS_W-1:0] sec,
                                            input logic [1:0] dir);
    plan_row_t row;
    row       = item_row(m, c, v);
    row.typed = 1'b1;
    row.want  = {seg, dig, ten, sec, dir};
    return row;
  endfunction

  function automatic plan_row_t reg_row(input logic idx, input logic data);
    plan_row_t row;
    row           = item_row(MODE_COUNT, CMD_UP, '0);
    row.is_write  = 1'b1;
    row.reg_index = idx;
    row.reg_data  = data;
    return row;
  endfunction

  function automatic timer_item_t random_item();
    timer_item_t it;
    int roll;
    // Fields that the chosen mode ignores still carry random noise.
    it.mode  = MODE_COUNT;
    it.cmd   = 3'($urandom_range(0, 7));
    it.value = SECONDS_W'($urandom_range(0, int'(VALUE_ALL_ONES)));
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      it.mode = MODE_COUNT;
    end else if (roll < 80) begin
      it.mode = MODE_SCAN;
    end else if (roll < 97) begin
      it.mode = MODE_COMMAND;
      roll = $urandom_range(0, 99);
      if (roll < 25) begin
        it.cmd = CMD_UP;
      end else if (roll < 50) begin
        it.cmd = CMD_DOWN;
      end else if (roll < 60) begin
        it.cmd = CMD_STOP;
      end else if (roll < 68) begin
        it.cmd = CMD_RESET;
      end else if (roll < 92) begin
        it.cmd = CMD_LOAD;
        // Loads at the ends of the range let the clamp and the saturation
        // happen within one second of counting.
        roll = $urandom_range(0, 2);
        if (roll == 0) begin
          it.value = SECONDS_W'($urandom_range(0, 1));
        end else if (roll == 1) begin
          it.value = SECONDS_TOP - 1'b1 + SECONDS_W'($urandom_range(0, 4));
        end
      end else begin
        it.cmd = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
      end
    end else begin
      it.mode = MODE_SPARE;
    end
    return it;
  endfunction

  task automatic offer_item(input timer_item_t it, input bit typed,
                            input timer_reading_t want);
    timer_reading_t got;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    mode          <= it.mode;
    command       <= it.cmd;
    seconds_value <= it.value;
    do @(posedge clk); while (!in_ready);
    advance_timer(it, got);
    expected_readings.push_back(typed ? want : got);
    items_sent++;
  endtask

  task automatic wait_for_readings();
    in_valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_DISPLAY_ENABLED) begin
      disp_on = data;
    end else begin
      show_count = data;
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    timer_reading_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_readings.size() == 0) begin
        $error("unexpected reading: tenths_count %0d, seconds_count %0d",
               tenths_count, seconds_count);
        failures++;
      end else begin
        want = expected_readings.pop_front();
        readings_checked++;
        if (segments !== want.seg) begin
          $error("segments: expected %h, got %h", want.seg, segments);
          failures++;
        end
        if (digit_enables !== want.dig) begin
          $error("digit_enables: expected %h, got %h", want.dig, digit_enables);
          failures++;
        end
        if (tenths_count !== want.tenths) begin
          $error("tenths_count: expected %0d, got %0d", want.tenths, tenths_count);
          failures++;
        end
        if (seconds_count !== want.secs) begin
          $error("seconds_count: expected %0d, got %0d", want.secs, seconds_count);
          failures++;
        end
        if (direction !== want.dir) begin
          $error("direction: expected %b, got %b", want.dir, direction);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timed out after %0d cycles without an accepted item", quiet_cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    plan_row_t      plan[$];
    timer_reading_t no_reading;
    timer_item_t    it;
    int             counted;

    in_valid      = 1'b0;
    mode          = MODE_COUNT;
    command       = CMD_UP;
    seconds_value = '0;
    cfg_valid     = 1'b0;
    cfg_index     = REG_DISPLAY_ENABLED;
    cfg_data      = 1'b0;
    out_ready     = 1'b0;
    rst           = 1'b1;
    no_reading    = '0;

    disp_on     = 1'b0;
    show_count  = 1'b0;
    tmr_tenths  = '0;
    tmr_secs    = '0;
    tmr_step    = STEP_STOP;
    tmr_subtick = 0;
    tmr_pos     = 2'd0;
    tmr_seg     = SEG_BLANK;
    tmr_dig     = 4'h0;

    // Ignored items after reset, then a downward count that wraps the
    // tenths and clamps the seconds at zero on the same tick.
    plan.push_back(checked_row(MODE_SCAN, CMD_UP, '0, SEG_BLANK, 4'h0, '0, '0, STEP_STOP));
    plan.push_back(checked_row(MODE_SPARE, CMD_UP, '0, SEG_BLANK, 4'h0, '0, '0, STEP_STOP));
    plan.push_back(checked_row(MODE_COMMAND, CMD_SPARE_FIRST, '0,
                               SEG_BLANK, 4'h0, '0, '0, STEP_STOP));
    plan.push_back(checked_row(MODE_COMMAND, CMD_SPARE_LAST, VALUE_ALL_ONES,
                               SEG_BLANK, 4'h0, '0, '0, STEP_STOP));
    plan.push_back(checked_row(MODE_COMMAND, CMD_DOWN, '0, SEG_BLANK, 4'h0, '0, '0, STEP_DOWN));
    plan.push_back(checked_row(MODE_COUNT, CMD_UP, '0,
                               SEG_BLANK, 4'h0, TENTHS_TOP, '0, STEP_STOP));
    plan.push_back(checked_row(MODE_COUNT, CMD_UP, '0,
                               SEG_BLANK, 4'h0, TENTHS_TOP, '0, STEP_STOP));
    plan.push_back(checked_row(MODE_COMMAND, CMD_LOAD, VALUE_ALL_ONES,
                               SEG_BLANK, 4'h0, TENTHS_TOP, SECONDS_TOP, STEP_STOP));
    plan.push_back(checked_row(MODE_COMMAND, CMD_UP, '0,
                               SEG_BLANK, 4'h0, TENTHS_TOP, SECONDS_TOP, STEP_UP));
    plan.push_back(checked_row(MODE_COUNT, CMD_UP, '0,
                               SEG_BLANK, 4'h0, '0, SECONDS_TOP, STEP_UP));
    repeat (7) plan.push_back(item_row(MODE_COUNT, CMD_UP, '0));
    // First tick of a new second with the seconds count already at the top.
    plan.push_back(checked_row(MODE_COUNT, CMD_UP, '0,
                               SEG_BLANK, 4'h0, 14'd8, SECONDS_TOP, STEP_UP));
    plan.push_back(reg_row(REG_DISPLAY_ENABLED, 1'b1));
    plan.push_back(reg_row(REG_SHOW_TIMER, 1'b1));
    repeat (4) plan.push_back(item_row(MODE_SCAN, CMD_UP, '0));
    plan.push_back(item_row(MODE_COMMAND, CMD_STOP, '0));
    plan.push_back(item_row(MODE_COMMAND, CMD_RESET, '0));
    plan.push_back(item_row(MODE_COMMAND, CMD_LOAD, SECONDS_TOP + 1'b1));
    plan.push_back(item_row(MODE_COUNT, CMD_UP, '0));

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        wait_for_readings();
        write_reg(plan[i].reg_index, plan[i].reg_data);
      end else begin
        offer_item(plan[i].item, plan[i].typed, plan[i].want);
      end
    end

    for (int p = 0; p < 4; p++) begin
      wait_for_readings();
      write_reg(REG_DISPLAY_ENABLED, DISP_BY_PHASE[p]);
      write_reg(REG_SHOW_TIMER, SHOW_BY_PHASE[p]);
      send_idle_pct  = IDLE_PCT[p];
      recv_stall_pct = STALL_PCT[p];
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        it = random_item();
        offer_item(it, 1'b0, no_reading);
        if (!(it.mode == MODE_SPARE || (it.mode == MODE_COMMAND && it.cmd > CMD_LOAD))) begin
          counted++;
        end
      end
    end
    wait_for_readings();

    $display("Sent %0d items (directed corner cases, then four random phases under", items_sent);
    $display("varied idling and display settings); %0d readings checked, %0d mismatches.",
             readings_checked, failures);
    if (failures == 0 && expected_readings.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
